// File: hdl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared sizes, request codes and the command type of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    // storage
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = IDX_W + 1;

    // fixed field widths of the channels
    localparam int KIND_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_PEEK_BACK  = 3'd2,
        KIND_PEEK_FRONT = 3'd3,
        KIND_POP_BACK   = 3'd4,
        KIND_POP_FRONT  = 3'd5,
        KIND_SIZE       = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_PEEK,
        OP_POP,
        OP_SIZE
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic                  at_front;
        logic [DATA_WIDTH-1:0] word;
    } t_cmd;

endpackage

// File: hdl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels carrying requests into and results out of the queue.
// ----------------------------------------------------------------------------
interface dq_req_if import dq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;

    modport source(output valid, kind, value, input ready);
    modport sink(input valid, kind, value, output ready);
endinterface

interface dq_rsp_if import dq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;
    logic                      error;
    logic [COUNT_W-1:0]        count;

    modport source(output valid, read_value, error, count, input ready);
    modport sink(input valid, read_value, error, count, output ready);
endinterface

// File: hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of words in a ring buffer with a head index and a count.
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request item: kind (push back/front, peek back/front,
//   pop back/front, size) and the word to push. o_rsp returns exactly one
//   result item per request, in order: the peeked word (zero otherwise), an
//   error flag for peek or pop while empty or push while full, and the count
//   held after the request.
//   an accepted request is written into the command queue, then the back
//   carries it out with the ring update and the registered memory read.
//   throughput: one item per cycle while o_rsp takes each result, set by the
//   single memory port and the head/count update that each request makes once.
//   reset clears head, count and all handshake state; the storage is not
//   cleared, as only entries inside the live range are ever read.
//   when o_rsp stalls the result register holds, the back stops and the
//   two-entry command queue fills before i_req.ready drops.
// ----------------------------------------------------------------------------
module double_ended_queue import dq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_req_if.sink   i_req,
    dq_rsp_if.source o_rsp
);

    logic front_valid, front_ready;
    t_cmd front_cmd;
    logic back_valid, back_ready;
    t_cmd back_cmd;

    dq_front u_front (
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    dq_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_cmd   (front_cmd),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_cmd   (back_cmd)
    );

    dq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .o_cmd_ready (back_ready),
        .i_cmd       (back_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

// File: hdl/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Accepts request items and turns the kind code into an operation and an end.
// ----------------------------------------------------------------------------
module dq_front import dq_pkg::*; (
    dq_req_if.sink i_req,
    output logic   o_cmd_valid,
    input  logic   i_cmd_ready,
    output t_cmd   o_cmd
);

    always_comb begin
        o_cmd.word     = DATA_WIDTH'($unsigned(i_req.value));
        o_cmd.at_front = 1'b0;
        o_cmd.op       = OP_SIZE;
        case (t_kind'(i_req.kind))
            KIND_PUSH_BACK: begin
                o_cmd.op = OP_PUSH;
            end
            KIND_PUSH_FRONT: begin
                o_cmd.op       = OP_PUSH;
                o_cmd.at_front = 1'b1;
            end
            KIND_PEEK_BACK: begin
                o_cmd.op = OP_PEEK;
            end
            KIND_PEEK_FRONT: begin
                o_cmd.op       = OP_PEEK;
                o_cmd.at_front = 1'b1;
            end
            KIND_POP_BACK: begin
                o_cmd.op = OP_POP;
            end
            KIND_POP_FRONT: begin
                o_cmd.op       = OP_POP;
                o_cmd.at_front = 1'b1;
            end
            // size, and the unused code
            default: begin
                o_cmd.op = OP_SIZE;
            end
        endcase
    end

    assign o_cmd_valid = i_req.valid;
    assign i_req.ready = i_cmd_ready;

endmodule

// File: hdl/dq_fifo.sv
// ----------------------------------------------------------------------------
// dq_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dq_fifo import dq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_cmd,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_cmd
);

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_fill, n_fill;
    logic               wr_en, rd_en;

    function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_wr_ready = (r_fill != Q_CNT_W'(Q_DEPTH));
    assign o_rd_valid = (r_fill != '0);
    assign o_rd_cmd   = r_slot[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = wr_en ? ptr_next(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = rd_en ? ptr_next(r_rd_ptr) : r_rd_ptr;
        n_fill   = r_fill;
        if (wr_en && !rd_en) begin
            n_fill = r_fill + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_wr_cmd;
        end
    end

`ifndef SYNTH
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= Q_CNT_W'(Q_DEPTH))
        else $error("command queue fill out of range");
    a_fill_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("command queue fill lost a write");
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("command queue pointers disagree while empty");
`endif

endmodule

// File: hdl/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Carries out commands on the ring buffer and holds the result item.
// ----------------------------------------------------------------------------
module dq_back import dq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_cmd     i_cmd,
    dq_rsp_if.source o_rsp
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_rsp_valid;
    logic                  r_rsp_peek, n_rsp_peek;
    logic                  r_rsp_err, n_rsp_err;
    logic [CNT_W-1:0]      r_rsp_count;
    logic                  exec, empty, full;
    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [SUM_W-1:0]      tail_sum, back_sum;
    logic [IDX_W-1:0]      tail_slot, back_slot, head_before, head_after;

    function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
        return (s >= SUM_W'(DEPTH)) ? IDX_W'(s - SUM_W'(DEPTH)) : IDX_W'(s);
    endfunction

    assign o_cmd_ready = !r_rsp_valid || o_rsp.ready;
    assign exec        = i_cmd_valid && o_cmd_ready;
    assign empty       = (r_count == '0);
    assign full        = (r_count == CNT_W'(DEPTH));

    // ring positions around the live range
    assign tail_sum    = SUM_W'(r_head) + SUM_W'(r_count);
    assign back_sum    = tail_sum - 1'b1;
    assign tail_slot   = wrap(tail_sum);
    assign back_slot   = wrap(back_sum);
    assign head_before = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - 1'b1;
    assign head_after  = (r_head == IDX_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_rsp_err  = 1'b0;
        n_rsp_peek = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        wr_addr    = i_cmd.at_front ? head_before : tail_slot;
        rd_addr    = i_cmd.at_front ? r_head : back_slot;
        case (i_cmd.op)
            OP_PUSH: begin
                if (full) begin
                    n_rsp_err = 1'b1;
                end else begin
                    wr_en   = exec;
                    n_count = r_count + 1'b1;
                    if (i_cmd.at_front) begin
                        n_head = head_before;
                    end
                end
            end
            OP_PEEK: begin
                if (empty) begin
                    n_rsp_err = 1'b1;
                end else begin
                    rd_en      = exec;
                    n_rsp_peek = 1'b1;
                end
            end
            OP_POP: begin
                if (empty) begin
                    n_rsp_err = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    if (i_cmd.at_front) begin
                        n_head = head_after;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
            if (exec) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_rsp_peek  <= n_rsp_peek;
            r_rsp_err   <= n_rsp_err;
            r_rsp_count <= n_count;
        end
    end

    // single-port ring storage, read data held until the next peek
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.word;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.error      = r_rsp_err;
    assign o_rsp.count      = COUNT_W'(r_rsp_count);
    assign o_rsp.read_value = r_rsp_peek ? $signed(VALUE_W'(r_rdata)) : '0;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(DEPTH)) && (r_head <= IDX_W'(DEPTH - 1)))
        else $error("head or count out of range");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !o_rsp.ready) |=>
            (r_rsp_valid && $stable(r_rsp_count) && $stable(r_rsp_err)))
        else $error("stalled result changed");
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (i_cmd.op == OP_POP) && !empty) |=>
            (r_count == $past(r_count) - 1'b1))
        else $error("pop did not remove an entry");
    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && (i_cmd.op == OP_PUSH) && full) |=>
            (o_rsp.error && $stable(r_count) && $stable(r_head)))
        else $error("push on a full queue changed the state");
`endif

endmodule
